// ===== hw/rtl/replay_window_dedup_filter_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the replay window duplicate filter
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef REPLAY_WINDOW_DEDUP_FILTER_UNIT_DEFINES_SVH
`define REPLAY_WINDOW_DEDUP_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Plain property that must hold at every clock edge out of reset.
`define RWDF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rwdf assertion failed");
// Implication: when the antecedent holds, the consequent must hold.
`define RWDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwdf implication failed");
// Next-cycle implication.
`define RWDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwdf next-cycle implication failed");
`else
`define RWDF_ASSERT(label, clk, rst_n, prop)
`define RWDF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RWDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/rwdf_pkg.sv =====
// ---------------------------------------------------------------------------
// Replay window duplicate filter package
// Field widths, register reset value and the sequencer state type.
// ---------------------------------------------------------------------------
package rwdf_pkg;

    // Payload field widths.
    localparam int ID_W   = 64;
    localparam int TIME_W = 32;
    localparam int OCC_W  = 7;

    // Reset value of the expiry register, in milliseconds.
    localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd300000;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_STORE = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

endpackage

// ===== hw/rtl/replay_window_dedup_filter_unit.sv =====
// ---------------------------------------------------------------------------
// Replay window duplicate filter
// Remembers recent message identifiers and flags repeats within a time window.
// ---------------------------------------------------------------------------
// Usage:
// Each input beat on s_* carries a 64-bit message identifier and the local
// millisecond time. The block prunes every remembered entry older than the
// expiry register, looks the identifier up among the survivors and, if it is
// new, stores it at the ring write pointer (overwriting the oldest entry when
// the ring is full). One output beat on m_* reports accepted and the
// occupancy after the item.
// Timing: one comparator walks the CAPACITY slots, one slot per cycle from a
// registered memory read; the item then passes through the store and output
// states before the block returns to idle. s_tready is high only while the
// block is idle.
// A stalled output beat is held until m_tready; no new item is taken before.
// Reset empties the ring (all valid bits clear), zeroes the write pointer and
// loads the expiry register with 300000 ms; no clearing pass is needed.
// The cfg channel writes the expiry register and is always ready; write it
// only while the block is idle.
// ---------------------------------------------------------------------------
`include "replay_window_dedup_filter_unit_defines.svh"

module replay_window_dedup_filter_unit
    import rwdf_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input item: [63:0] msg_id, [95:64] now_ms
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,
    // Result item: [0] accepted, [7:1] occupancy
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    // Expiry register write: [31:0] expiry_ms
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

    // Identifier and seen-time memories.
    logic [ID_W-1:0]   id_mem   [CAPACITY];
    logic [TIME_W-1:0] time_mem [CAPACITY];

    state_t              state_reg, state_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]    wp_reg, wp_next;
    logic [TIME_W-1:0]   expiry_reg;
    logic [ID_W-1:0]     id_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [CNT_W-1:0]    addr_reg, addr_next;
    logic                pend_reg;
    logic [IDX_W-1:0]    proc_idx_reg;
    logic [ID_W-1:0]     rd_id_reg;
    logic [TIME_W-1:0]   rd_time_reg;
    logic                dup_reg, dup_next;
    logic                wp_live_reg, wp_live_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic                acc_reg, acc_next;

    logic [IDX_W-1:0]    rd_addr;
    logic [TIME_W-1:0]   age;
    logic                ent_valid;
    logic                survive;
    logic                mem_we;
    logic                in_beat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;
    assign m_tdata   = {OCC_W'(occ_reg), acc_reg};
    assign in_beat   = s_tvalid && s_tready;
    assign rd_addr   = addr_reg[IDX_W-1:0];
    assign mem_we    = (state_reg == ST_STORE) && !dup_reg;

    // Shared compare unit: age check and valid bit for one slot.
    assign age       = now_reg - rd_time_reg;
    assign ent_valid = valid_reg[proc_idx_reg];
    assign survive   = ent_valid && !(age > expiry_reg);

    // Memory write on store, registered read during the sweep.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[wp_reg]   <= id_reg;
            time_mem[wp_reg] <= now_reg;
        end
        rd_id_reg   <= id_mem[rd_addr];
        rd_time_reg <= time_mem[rd_addr];
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        wp_next      = wp_reg;
        addr_next    = addr_reg;
        dup_next     = dup_reg;
        wp_live_next = wp_live_reg;
        cnt_next     = cnt_reg;
        occ_next     = occ_reg;
        acc_next     = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    addr_next    = '0;
                    dup_next     = 1'b0;
                    wp_live_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (addr_reg != CNT_CAP)
                begin
                    addr_next = addr_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (ent_valid && !survive)
                    begin
                        valid_next[proc_idx_reg] = 1'b0;
                    end
                    if (survive)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (rd_id_reg == id_reg)
                        begin
                            dup_next = 1'b1;
                        end
                    end
                    if (proc_idx_reg == wp_reg)
                    begin
                        wp_live_next = survive;
                    end
                end
                if (addr_reg == CNT_CAP)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                acc_next = !dup_reg;
                if (dup_reg)
                begin
                    occ_next = cnt_reg;
                end
                else
                begin
                    valid_next[wp_reg] = 1'b1;
                    wp_next  = (wp_reg == IDX_LAST) ? '0 : wp_reg + IDX_W'(1);
                    occ_next = wp_live_reg ? cnt_reg : cnt_reg + CNT_W'(1);
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            wp_reg       <= '0;
            expiry_reg   <= EXPIRY_RESET;
            addr_reg     <= '0;
            pend_reg     <= 1'b0;
            dup_reg      <= 1'b0;
            wp_live_reg  <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            wp_reg       <= wp_next;
            addr_reg     <= addr_next;
            pend_reg     <= (state_reg == ST_SWEEP) && (addr_reg != CNT_CAP);
            dup_reg      <= dup_next;
            wp_live_reg  <= wp_live_next;
            cnt_reg      <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                expiry_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            id_reg  <= s_tdata[ID_W-1:0];
            now_reg <= s_tdata[ID_W+TIME_W-1:ID_W];
        end
        proc_idx_reg <= rd_addr;
        occ_reg      <= occ_next;
        acc_reg      <= acc_next;
    end

    // Checks on the sequencer.
    `RWDF_ASSERT(a_not_both_sides, clk, rst_n, !(s_tready && m_tvalid))
    `RWDF_ASSERT_IMPL(a_occ_bound, clk, rst_n, m_tvalid, occ_reg <= CNT_CAP)
    `RWDF_ASSERT_IMPL(a_accept_nonempty, clk, rst_n, m_tvalid && acc_reg, occ_reg != '0)
    `RWDF_ASSERT_NEXT(a_store_sets_valid, clk, rst_n, (state_reg == ST_STORE) && !dup_reg, valid_reg[$past(wp_reg)])

endmodule
